FILE: design/turbine_governor_residual_unit_macros.svh
// assertion macros for the turbine governor residual unit
`ifndef TURBINE_GOVERNOR_RESIDUAL_UNIT_MACROS_SVH
`define TURBINE_GOVERNOR_RESIDUAL_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define TGR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgr check failed");

// next-cycle implication checked on every clock edge outside reset
`define TGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgr check failed");

`endif

FILE: design/tgr_pkg.sv
`default_nettype none
package tgr_pkg;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_HALF = 32'sd32768;
  localparam int NSTAGE = 18;

  typedef enum logic [2:0] {
    REG_INV_DROOP = 3'd0, REG_VALVE_MIN = 3'd1, REG_VALVE_MAX = 3'd2,
    REG_INV_VALVE_TIME = 3'd3, REG_LEAD_TIME = 3'd4, REG_INV_LAG_TIME = 3'd5,
    REG_DAMPING = 3'd6, REG_SIGMOID_GAIN = 3'd7
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round a 64-bit Q32.32 product to Q16.16 with saturation
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [65:0] t;
    t = (66'(p) + 66'sd32768) >>> 16;
    return sat32(t);
  endfunction
endpackage
`default_nettype wire

FILE: design/turbine_governor_residual_unit.sv
// turbine governor residual unit
// input channel s_axis_*: one word per evaluation point, seven signed Q16.16
// fields; output channel m_axis_*: three saturated Q16.16 residuals.
// configuration: cfg_we/cfg_index/cfg_data write one of eight registers;
// the user must write only while the pipeline is empty; the block does not enforce it.
// the unit is a fixed pipeline of 18 register stages: one word enters per
// cycle unless the output stalls; throughput is one word per cycle since
// no stage feeds back on itself: each stage is at most one multiply deep
// and the sigmoid divisions are unrolled restoring dividers, two quotient
// bits per stage over eight stages. reset clears all valid bits and
// loads the register reset values.
// when m_axis_tready is low and the last stage holds a result, the whole
// pipeline holds; s_axis_tready is low only in that case.
`default_nettype none
module turbine_governor_residual_unit
  import tgr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // turbine_state, valve_position, mech_power, turbine_rate, valve_rate,
  // shaft_speed, power_reference
  input  wire logic [223:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // turbine_residual, valve_residual, power_residual
  output logic [95:0]       m_axis_tdata
);
`include "turbine_governor_residual_unit_macros.svh"

  logic [30:0] inv_droop, inv_valve_time, lead_time, inv_lag_time, sigmoid_gain;
  logic signed [31:0] valve_min, valve_max, damping;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_droop <= 31'd1310720;
      valve_min <= '0;
      valve_max <= 32'sd65536;
      inv_valve_time <= 31'd131072;
      lead_time <= 31'd163840;
      inv_lag_time <= 31'd8738;
      damping <= '0;
      sigmoid_gain <= 31'd6553600;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INV_DROOP: inv_droop <= cfg_data[30:0];
        REG_VALVE_MIN: valve_min <= cfg_data;
        REG_VALVE_MAX: valve_max <= cfg_data;
        REG_INV_VALVE_TIME: inv_valve_time <= cfg_data[30:0];
        REG_LEAD_TIME: lead_time <= cfg_data[30:0];
        REG_INV_LAG_TIME: inv_lag_time <= cfg_data[30:0];
        REG_DAMPING: damping <= cfg_data;
        REG_SIGMOID_GAIN: sigmoid_gain <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  typedef logic signed [31:0] q_t;
  typedef struct packed {
    q_t ptx, pv, pm, ptxd, pvd, spd, pref;
    q_t err, brk, f, nf, lb, lead, dmp, r0;
    q_t m0, m1, m2, m3;
    logic [31:0] d0, d1, d2, d3;
    logic [33:0] r0m, r1m, r2m, r3m;
    logic [16:0] qt0, qt1, qt2, qt3;
    q_t s0, s1, s2, s3, lo, hi, ind;
  } pipe_t;

  pipe_t st [NSTAGE];
  logic  vld [NSTAGE];
  logic  adv;
  assign adv = m_axis_tready || !vld[NSTAGE-1];
  assign s_axis_tready = adv;

  function automatic q_t qm(input q_t a, input q_t b);
    return qround(64'(a) * 64'(b));
  endfunction
  function automatic q_t qmu(input q_t a, input logic [30:0] b);
    return qround(64'(a) * 64'($signed({1'b0, b})));
  endfunction
  function automatic q_t absq(input q_t m);
    return m[31] ? -m : m;
  endfunction
  // one restoring quotient step on |m|*2^16 over 2*(2^16+|m|)
  function automatic void dstep(input logic [33:0] r, input logic [31:0] d,
                                input logic [16:0] q,
                                output logic [33:0] ro, output logic [16:0] qo);
    logic [34:0] t;
    t = {r, 1'b0};
    if (t >= {2'b0, d, 1'b0}) begin
      ro = 34'(t - {2'b0, d, 1'b0});
      qo = {q[15:0], 1'b1};
    end else begin
      ro = t[33:0];
      qo = {q[15:0], 1'b0};
    end
  endfunction
  function automatic q_t sfin(input q_t m, input logic [16:0] q);
    q_t v;
    v = $signed({15'd0, q});
    return m[31] ? Q_HALF - v : Q_HALF + v;
  endfunction

  pipe_t nx [NSTAGE];
  always_comb begin
    pipe_t a;
    logic [33:0] rr;
    logic [16:0] qq;
    // stage 0: capture, err, lead-time and damping products
    a = '0;
    a.ptx = s_axis_tdata[31:0];
    a.pv = s_axis_tdata[63:32];
    a.pm = s_axis_tdata[95:64];
    a.ptxd = s_axis_tdata[127:96];
    a.pvd = s_axis_tdata[159:128];
    a.spd = s_axis_tdata[191:160];
    a.pref = s_axis_tdata[223:192];
    a.err = sat32(66'(a.pref) - 66'(a.spd));
    a.lb = qmu(a.pv, lead_time);
    a.dmp = qm(damping, a.spd);
    nx[0] = a;
    // stage 1: brk, lead bracket
    a = st[0];
    a.brk = sat32(66'(qmu(a.err, inv_droop)) - 66'(a.pv));
    a.lb = sat32(66'(a.ptx) + 66'(a.lb));
    nx[1] = a;
    // stage 2: f, lead
    a = st[1];
    a.f = qmu(a.brk, inv_valve_time);
    a.lead = qmu(a.lb, inv_lag_time);
    nx[2] = a;
    // stage 3: sigmoid arguments, r0 and power residual into r0/dmp
    a = st[2];
    a.nf = sat32(-66'(a.f));
    a.m0 = sat32(66'(valve_min) - 66'(a.pv));
    a.m2 = sat32(66'(a.pv) - 66'(valve_max));
    a.r0 = sat32(66'(a.pv) - 66'(a.ptxd) - 66'(a.lead));
    a.dmp = sat32(66'(a.lead) - 66'(a.pm) - 66'(a.dmp));
    nx[3] = a;
    // stage 4: gain products
    a = st[3];
    a.m0 = qmu(a.m0, sigmoid_gain);
    a.m1 = qmu(a.nf, sigmoid_gain);
    a.m2 = qmu(a.m2, sigmoid_gain);
    a.m3 = qmu(a.f, sigmoid_gain);
    nx[4] = a;
    // stage 5: divisor setup and first dividend
    a = st[4];
    a.d0 = 32'(33'h10000 + {1'b0, absq(a.m0)});
    a.d1 = 32'(33'h10000 + {1'b0, absq(a.m1)});
    a.d2 = 32'(33'h10000 + {1'b0, absq(a.m2)});
    a.d3 = 32'(33'h10000 + {1'b0, absq(a.m3)});
    a.r0m = {2'b0, absq(a.m0)};
    a.r1m = {2'b0, absq(a.m1)};
    a.r2m = {2'b0, absq(a.m2)};
    a.r3m = {2'b0, absq(a.m3)};
    a.qt0 = '0; a.qt1 = '0; a.qt2 = '0; a.qt3 = '0;
    nx[5] = a;
    // stages 6..13: two quotient bits per stage, 16 in all
    for (int k = 6; k < 14; k++) begin
      a = st[k-1];
      for (int j = 0; j < 2; j++) begin
        dstep(a.r0m, a.d0, a.qt0, rr, qq); a.r0m = rr; a.qt0 = qq;
        dstep(a.r1m, a.d1, a.qt1, rr, qq); a.r1m = rr; a.qt1 = qq;
        dstep(a.r2m, a.d2, a.qt2, rr, qq); a.r2m = rr; a.qt2 = qq;
        dstep(a.r3m, a.d3, a.qt3, rr, qq); a.r3m = rr; a.qt3 = qq;
      end
      nx[k] = a;
    end
    // stage 14: sigmoid values
    a = st[13];
    a.s0 = sfin(a.m0, a.qt0);
    a.s1 = sfin(a.m1, a.qt1);
    a.s2 = sfin(a.m2, a.qt2);
    a.s3 = sfin(a.m3, a.qt3);
    nx[14] = a;
    // stage 15: sigmoid products
    a = st[14];
    a.lo = qm(a.s0, a.s1);
    a.hi = qm(a.s2, a.s3);
    nx[15] = a;
    // stage 16: indicator
    a = st[15];
    a.ind = qm(Q_ONE - a.lo, Q_ONE - a.hi);
    nx[16] = a;
    // stage 17: valve residual
    a = st[16];
    a.brk = sat32(66'(qm(a.ind, a.f)) - 66'(a.pvd));
    nx[17] = a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTAGE; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTAGE; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTAGE; k++) st[k] <= nx[k];
    end
  end

  assign m_axis_tvalid = vld[NSTAGE-1];
  assign m_axis_tdata = {st[NSTAGE-1].dmp, st[NSTAGE-1].brk, st[NSTAGE-1].r0};

  `TGR_ASSERT_IMP(a_ready_when_empty, !vld[NSTAGE-1], s_axis_tready)
  `TGR_ASSERT_NEXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `TGR_ASSERT_NEXT(a_advance, s_axis_tvalid && s_axis_tready, vld[0])
endmodule
`default_nettype wire
